// ----- rtl/core/siir2_pkg.sv -----
// Package for the shift-coefficient second-order low-pass filter.
// Holds the field widths, request codes, history and result types and
// the shift helpers; it depends on nothing else.
`timescale 1ns / 1ps

package siir2_pkg;

	// Extra fraction bits carried by the history values.
	localparam int FRAC_BITS   = 16;
	localparam int SAMPLE_W    = 16;
	localparam int PRECISE_W   = 32;
	localparam int SHIFT_W     = 5;
	// Wide enough for a = 2b + 4 with b up to its full code range.
	localparam int AMOUNT_W    = 7;

	localparam logic [SHIFT_W-1:0]  B_RESET      = 5'd20;
	localparam logic [SAMPLE_W-1:0] PEAK_INVALID = 16'h8000;

	// Request codes carried on the input user field.
	typedef enum logic [1:0] {
		REQ_INIT        = 2'd0,
		REQ_ADD         = 2'd1,
		REQ_ADD_PRECISE = 2'd2
	} req_t;

	// Filter history. Only the two newest inputs are ever read again.
	typedef struct packed {
		logic [PRECISE_W-1:0] x0;
		logic [PRECISE_W-1:0] x1;
		logic [PRECISE_W-1:0] y0;
		logic [PRECISE_W-1:0] y1;
		logic [PRECISE_W-1:0] y2;
	} hist_t;

	// One result item.
	typedef struct packed {
		logic [SAMPLE_W-1:0]  filtered;
		logic [PRECISE_W-1:0] filtered_precise;
		logic [PRECISE_W-1:0] prev_filtered_precise;
		logic [SAMPLE_W-1:0]  latest_input;
		logic [SAMPLE_W-1:0]  pos_peak;
		logic [SAMPLE_W-1:0]  neg_peak;
	} result_t;

	// Arithmetic shift right; amounts of 31 or more give pure sign fill.
	function automatic logic [PRECISE_W-1:0] asr32(input logic [PRECISE_W-1:0] x,
			input logic [AMOUNT_W-1:0] n);
		logic [PRECISE_W-1:0] r;
		if (n >= AMOUNT_W'(31)) begin
			r = {PRECISE_W{x[PRECISE_W-1]}};
		end else begin
			r = PRECISE_W'($signed(x) >>> n[4:0]);
		end
		return r;
	endfunction

	// Sign-extend a regular sample and move it up to full precision.
	function automatic logic [PRECISE_W-1:0] widen(input logic [SAMPLE_W-1:0] s);
		logic [PRECISE_W-1:0] e;
		e = {{(PRECISE_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
		return PRECISE_W'(e << FRAC_BITS);
	endfunction

	// Bring a full-precision value back to regular precision.
	function automatic logic [SAMPLE_W-1:0] to_regular(input logic [PRECISE_W-1:0] v);
		logic [PRECISE_W-1:0] t;
		t = asr32(v, AMOUNT_W'(FRAC_BITS));
		return t[SAMPLE_W-1:0];
	endfunction

endpackage

// ----- rtl/core/siir2_step.sv -----
// Combinational filter step: applies one request to the history and forms
// the result item from the updated history. Depends on siir2_pkg.
`timescale 1ns / 1ps

module siir2_step (
	input  logic [1:0]                          req,
	input  logic [siir2_pkg::SAMPLE_W-1:0]      sample,
	input  logic [siir2_pkg::PRECISE_W-1:0]     sample_precise,
	input  logic [siir2_pkg::SHIFT_W-1:0]       coef_b,
	input  siir2_pkg::hist_t                    hist,
	output siir2_pkg::hist_t                    hist_next,
	output siir2_pkg::result_t                  result
);

	logic [siir2_pkg::AMOUNT_W-1:0]  sh_b;
	logic [siir2_pkg::AMOUNT_W-1:0]  sh_a;
	logic [siir2_pkg::AMOUNT_W-1:0]  sh_a1;
	logic [siir2_pkg::AMOUNT_W-1:0]  sh_a2;
	logic [siir2_pkg::PRECISE_W-1:0] x_new;
	logic [siir2_pkg::PRECISE_W-1:0] acc;
	logic [siir2_pkg::PRECISE_W-1:0] wide_sample;

	// Shift amounts derived from b.
	assign sh_b  = siir2_pkg::AMOUNT_W'(coef_b);
	assign sh_a  = siir2_pkg::AMOUNT_W'({coef_b, 1'b0}) + siir2_pkg::AMOUNT_W'(4);
	assign sh_a1 = sh_a - siir2_pkg::AMOUNT_W'(1);
	assign sh_a2 = sh_a - siir2_pkg::AMOUNT_W'(2);

	assign wide_sample = siir2_pkg::widen(sample);
	assign x_new = (req == siir2_pkg::REQ_ADD_PRECISE) ? sample_precise : wide_sample;

	// Recurrence with wrapping 32-bit sums; y0 and y1 are the outputs
	// before this step, x0 and x1 the inputs before it.
	assign acc = (hist.y0 - hist.y1) + hist.y0
		- siir2_pkg::asr32(hist.y0, sh_b) + siir2_pkg::asr32(hist.y1, sh_b)
		+ siir2_pkg::asr32(x_new, sh_a) + siir2_pkg::asr32(hist.x0, sh_a1)
		+ siir2_pkg::asr32(hist.x1, sh_a)
		- siir2_pkg::asr32(hist.y1, sh_a2);

	// History update by request code; the unused code leaves it alone.
	always_comb begin
		case (req)
			siir2_pkg::REQ_INIT: begin
				hist_next.x0 = wide_sample;
				hist_next.x1 = wide_sample;
				hist_next.y0 = wide_sample;
				hist_next.y1 = wide_sample;
				hist_next.y2 = wide_sample;
			end
			siir2_pkg::REQ_ADD, siir2_pkg::REQ_ADD_PRECISE: begin
				hist_next.x0 = x_new;
				hist_next.x1 = hist.x0;
				hist_next.y0 = acc;
				hist_next.y1 = hist.y0;
				hist_next.y2 = hist.y1;
			end
			default: begin
				hist_next = hist;
			end
		endcase
	end

	// Result fields and peak detection on the updated history.
	always_comb begin
		result.filtered              = siir2_pkg::to_regular(hist_next.y0);
		result.filtered_precise      = hist_next.y0;
		result.prev_filtered_precise = hist_next.y1;
		result.latest_input          = siir2_pkg::to_regular(hist_next.x0);
		if (($signed(hist_next.y0) < $signed(hist_next.y1))
				&& ($signed(hist_next.y1) >= $signed(hist_next.y2))) begin
			result.pos_peak = siir2_pkg::to_regular(hist_next.y1);
		end else begin
			result.pos_peak = siir2_pkg::PEAK_INVALID;
		end
		if (($signed(hist_next.y0) > $signed(hist_next.y1))
				&& ($signed(hist_next.y1) <= $signed(hist_next.y2))) begin
			result.neg_peak = siir2_pkg::to_regular(hist_next.y1);
		end else begin
			result.neg_peak = siir2_pkg::PEAK_INVALID;
		end
	end

endmodule

// ----- rtl/core/shift_iir2_lowpass_peak.sv -----
// Top level of the shift-coefficient second-order low-pass filter with
// peak detection. Depends on siir2_pkg and siir2_step.
`timescale 1ns / 1ps

// Usage:
// Input items arrive on the s_ stream channel: s_tuser carries the request
// code (init history, add regular sample, add precise sample) and s_tdata
// the regular and precise samples. Each item yields exactly one result item
// on the m_ stream channel with the filtered output, the previous output,
// the latest input and the positive and negative peak codes.
// An accepted item sits in an input register; once the output register is
// free or being emptied, the filter step runs in one pass of logic, the
// history is updated and the result is written to the output register.
// While the receiver keeps m_tready high, one item per cycle is sustained,
// limited by the history feedback through the step logic.
// The user must write the shift setting b through cfg_we / cfg_wdata only
// while the block is idle; the block does not enforce this. Reset clears
// the history to zero, sets b to 20 and empties both registers. When the
// receiver stalls, the result holds in the output register, one more item
// waits in the input register, and s_tready falls until the result is taken.
module shift_iir2_lowpass_peak (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [siir2_pkg::SHIFT_W-1:0]   cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: sample [15:0], sample_precise [47:16]
	input  logic [47:0]                     s_tdata,
	// s_tuser: req_type [1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: filtered [15:0], filtered_precise [47:16],
	// prev_filtered_precise [79:48], latest_input [95:80],
	// pos_peak [111:96], neg_peak [127:112]
	output logic [127:0]                    m_tdata
);

	logic                            valid_s1;
	logic [1:0]                      req_s1;
	logic [siir2_pkg::SAMPLE_W-1:0]  sample_s1;
	logic [siir2_pkg::PRECISE_W-1:0] precise_s1;
	logic [siir2_pkg::SHIFT_W-1:0]   coef_b_q;
	siir2_pkg::hist_t                hist_q;
	siir2_pkg::hist_t                hist_next;
	siir2_pkg::result_t              result;
	siir2_pkg::result_t              res_q;
	logic                            out_valid_q;
	logic                            fire;
	logic                            s_accept;

	// The step runs when the input register holds an item and the output
	// register is free or being emptied in this cycle.
	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign s_accept = s_tvalid && s_tready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b_q <= siir2_pkg::B_RESET;
		end else if (cfg_we) begin
			coef_b_q <= cfg_wdata;
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_s1     <= s_tuser;
			sample_s1  <= s_tdata[15:0];
			precise_s1 <= s_tdata[47:16];
		end
	end

	siir2_step u_step (
		.req            (req_s1),
		.sample         (sample_s1),
		.sample_precise (precise_s1),
		.coef_b         (coef_b_q),
		.hist           (hist_q),
		.hist_next      (hist_next),
		.result         (result)
	);

	// Filter history, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (fire) begin
			hist_q <= hist_next;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.neg_peak, res_q.pos_peak, res_q.latest_input,
		res_q.prev_filtered_precise, res_q.filtered_precise, res_q.filtered};

`ifndef SYNTHESIS
	// A processed item always leaves a result in the output register.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("processed item left no result");

	// An empty input register never blocks the input channel.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input blocked with empty input register");

	// An init request fills every history value with the same sample.
	a_init_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (req_s1 == siir2_pkg::REQ_INIT)) |=>
		((hist_q.x0 == hist_q.y2) && (hist_q.x1 == hist_q.y2)
		&& (hist_q.y0 == hist_q.y2) && (hist_q.y1 == hist_q.y2)))
		else $error("init did not fill history");

	// An add request moves the output and input history down by one place.
	a_add_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ((req_s1 == siir2_pkg::REQ_ADD) || (req_s1 == siir2_pkg::REQ_ADD_PRECISE)))
		|=> ((hist_q.y1 == $past(hist_q.y0)) && (hist_q.y2 == $past(hist_q.y1))
		&& (hist_q.x1 == $past(hist_q.x0))))
		else $error("add did not shift history");

	// History changes only when an item is processed.
	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(hist_q))
		else $error("history changed without an item");
`endif

endmodule
